// File: design/pcb_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the pixel convert and blend core.
// Used by every other design file but pcb_ifs; depends on nothing.
package pcb_pkg;

	localparam int unsigned NUM_LAYERS = 3;
	localparam int unsigned WORD_W     = 32;
	localparam int unsigned YCC_W      = 20;

	typedef enum logic [1:0] {
		KIND_RGB565 = 2'd0,
		KIND_XRGB   = 2'd1,
		KIND_ARGB   = 2'd2,
		KIND_YCC    = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		FAC_ZERO   = 4'd0,
		FAC_ONE    = 4'd1,
		FAC_INV_A  = 4'd4,
		FAC_A      = 4'd5,
		FAC_INV_G  = 4'd8,
		FAC_G      = 4'd9,
		FAC_INV_AG = 4'd10,
		FAC_AG     = 4'd11
	} fsel_t;

	localparam logic [1:0]        LAYER_CURSOR = 2'd3;
	localparam logic [WORD_W-1:0] CURSOR_WORD  = 32'h1000_0000;
	localparam logic [7:0]        OPAQUE       = 8'hff;

	// Reciprocals for exact floor division: x/31 for x <= 31*255,
	// x/63 for x <= 63*255 and x/255 for x < 2^17.
	localparam logic [13:0] REC31  = 14'd8457;
	localparam int unsigned SH31   = 18;
	localparam logic [14:0] REC63  = 15'd16645;
	localparam int unsigned SH63   = 20;
	localparam logic [17:0] REC255 = 18'd131587;
	localparam int unsigned SH255  = 25;

	localparam logic signed [YCC_W-1:0] YCC_Y     = 20'sd298;
	localparam logic signed [YCC_W-1:0] YCC_CR_R  = 20'sd409;
	localparam logic signed [YCC_W-1:0] YCC_CB_G  = 20'sd100;
	localparam logic signed [YCC_W-1:0] YCC_CR_G  = 20'sd208;
	localparam logic signed [YCC_W-1:0] YCC_CB_B  = 20'sd516;
	localparam logic signed [YCC_W-1:0] YCC_ROUND = 20'sd128;
	localparam logic signed [YCC_W-1:0] YCC_Y_OFS = 20'sd16;
	localparam logic signed [YCC_W-1:0] YCC_C_OFS = 20'sd128;

	localparam logic [16:0] BLEND_ROUND = 17'd127;

	typedef struct packed {
		logic [3:0] sf_sel;
		logic [3:0] df_sel;
		logic [7:0] galpha;
	} blend_t;

	typedef struct packed {
		logic [7:0]  a;
		logic [7:0]  r;
		logic [7:0]  g;
		logic [7:0]  b;
		logic [23:0] dest;
		blend_t      blend;
		logic [7:0]  ag;
	} expd_t;

	function automatic blend_t unpack_blend(logic [WORD_W-1:0] w);
		blend_t f;
		f.sf_sel = w[31:28];
		f.df_sel = w[15:12];
		f.galpha = w[7:0];
		return f;
	endfunction

	function automatic logic [7:0] clamp_ycc(logic signed [YCC_W-1:0] v);
		logic [7:0] res;
		if (v < 0) begin
			res = 8'd0;
		end else if (v[YCC_W-1:16] != '0) begin
			res = 8'hff;
		end else begin
			res = v[15:8];
		end
		return res;
	endfunction

	function automatic logic [7:0] factor(logic [3:0] sel, logic [7:0] a, logic [7:0] g,
		logic [7:0] ag);
		logic [7:0] f;
		unique case (fsel_t'(sel))
			FAC_ONE:    f = 8'hff;
			FAC_INV_A:  f = 8'hff - a;
			FAC_A:      f = a;
			FAC_INV_G:  f = 8'hff - g;
			FAC_G:      f = g;
			FAC_INV_AG: f = 8'hff - ag;
			FAC_AG:     f = ag;
			default:    f = 8'd0;
		endcase
		return f;
	endfunction

endpackage

// File: design/pcb_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the pixel input and the result output.
// Stand alone; the core uses the sink side of one and the source side of the other.
interface pcb_pix_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [1:0]  layer;
	logic [31:0] source_word;
	logic [23:0] dest_pixel;

	modport source(output valid, kind, layer, source_word, dest_pixel, input ready);
	modport sink(input valid, kind, layer, source_word, dest_pixel, output ready);
endinterface

interface pcb_res_if;
	logic        valid;
	logic        ready;
	logic [31:0] blended_pixel;
	logic [15:0] packed_rgb565;

	modport source(output valid, blended_pixel, packed_rgb565, input ready);
	modport sink(input valid, blended_pixel, packed_rgb565, output ready);
endinterface

// File: design/pcb_expand.sv
`timescale 1ns / 1ps
// Stages one and two: source expansion to ARGB, blend word selection and a*g/255.
// Depends on pcb_pkg.
module pcb_expand (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic                        in_valid,
	input  logic [1:0]                  kind,
	input  logic [1:0]                  layer,
	input  logic [31:0]                 source_word,
	input  logic [23:0]                 dest_pixel,
	input  logic [pcb_pkg::WORD_W-1:0]  words [pcb_pkg::NUM_LAYERS],
	output logic                        out_valid,
	output pcb_pkg::expd_t              out_data
);

	logic [pcb_pkg::WORD_W-1:0]        word;
	logic [7:0]                        alpha;
	logic signed [pcb_pkg::YCC_W-1:0]  c_w, d_w, e_w;
	logic signed [pcb_pkg::YCC_W-1:0]  r_sum, g_sum, b_sum;
	logic [12:0]                       num_r, num_b;
	logic [13:0]                       num_g;
	pcb_pkg::blend_t                   blend;

	logic                              valid_s1;
	pcb_pkg::kind_t                    kind_s1;
	logic [23:0]                       rgb_s1;
	logic [7:0]                        alpha_s1;
	logic [23:0]                       dest_s1;
	pcb_pkg::blend_t                   blend_s1;
	logic [15:0]                       ag_prod_s1;
	logic [12:0]                       num_r_s1, num_b_s1;
	logic [13:0]                       num_g_s1;
	logic signed [pcb_pkg::YCC_W-1:0]  r_sum_s1, g_sum_s1, b_sum_s1;

	logic [26:0]                       q_r, q_b;
	logic [28:0]                       q_g;
	logic [33:0]                       q_ag;
	pcb_pkg::expd_t                    expd;

	always_comb begin
		if (layer == pcb_pkg::LAYER_CURSOR) begin
			word = pcb_pkg::CURSOR_WORD;
		end else begin
			word = words[layer];
		end
		blend = pcb_pkg::unpack_blend(word);
		alpha = (pcb_pkg::kind_t'(kind) == pcb_pkg::KIND_ARGB) ? source_word[31:24]
			: pcb_pkg::OPAQUE;

		c_w = pcb_pkg::YCC_W'(source_word[23:16]) - pcb_pkg::YCC_Y_OFS;
		d_w = pcb_pkg::YCC_W'(source_word[15:8]) - pcb_pkg::YCC_C_OFS;
		e_w = pcb_pkg::YCC_W'(source_word[7:0]) - pcb_pkg::YCC_C_OFS;
		r_sum = c_w * pcb_pkg::YCC_Y + e_w * pcb_pkg::YCC_CR_R + pcb_pkg::YCC_ROUND;
		g_sum = c_w * pcb_pkg::YCC_Y - d_w * pcb_pkg::YCC_CB_G - e_w * pcb_pkg::YCC_CR_G
			+ pcb_pkg::YCC_ROUND;
		b_sum = c_w * pcb_pkg::YCC_Y + d_w * pcb_pkg::YCC_CB_B + pcb_pkg::YCC_ROUND;

		num_r = (13'(source_word[15:11]) << 8) - 13'(source_word[15:11]);
		num_g = (14'(source_word[10:5]) << 8) - 14'(source_word[10:5]);
		num_b = (13'(source_word[4:0]) << 8) - 13'(source_word[4:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1    <= pcb_pkg::kind_t'(kind);
			rgb_s1     <= source_word[23:0];
			alpha_s1   <= alpha;
			dest_s1    <= dest_pixel;
			blend_s1   <= blend;
			ag_prod_s1 <= 16'(alpha) * 16'(blend.galpha);
			num_r_s1   <= num_r;
			num_g_s1   <= num_g;
			num_b_s1   <= num_b;
			r_sum_s1   <= r_sum;
			g_sum_s1   <= g_sum;
			b_sum_s1   <= b_sum;
		end
	end

	always_comb begin
		q_r  = 27'(num_r_s1) * 27'(pcb_pkg::REC31);
		q_g  = 29'(num_g_s1) * 29'(pcb_pkg::REC63);
		q_b  = 27'(num_b_s1) * 27'(pcb_pkg::REC31);
		q_ag = 34'(ag_prod_s1) * 34'(pcb_pkg::REC255);

		expd.a     = alpha_s1;
		expd.dest  = dest_s1;
		expd.blend = blend_s1;
		expd.ag    = q_ag[pcb_pkg::SH255+7:pcb_pkg::SH255];
		unique case (kind_s1)
			pcb_pkg::KIND_RGB565: begin
				expd.r = q_r[pcb_pkg::SH31+7:pcb_pkg::SH31];
				expd.g = q_g[pcb_pkg::SH63+7:pcb_pkg::SH63];
				expd.b = q_b[pcb_pkg::SH31+7:pcb_pkg::SH31];
			end
			pcb_pkg::KIND_YCC: begin
				expd.r = pcb_pkg::clamp_ycc(r_sum_s1);
				expd.g = pcb_pkg::clamp_ycc(g_sum_s1);
				expd.b = pcb_pkg::clamp_ycc(b_sum_s1);
			end
			default: begin
				expd.r = rgb_s1[23:16];
				expd.g = rgb_s1[15:8];
				expd.b = rgb_s1[7:0];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data <= expd;
		end
	end

endmodule

// File: design/pcb_blend.sv
`timescale 1ns / 1ps
// Stages three to five: factor selection, channel products, sum and divide by 255.
// Depends on pcb_pkg; the last stage is the output register of the core.
module pcb_blend (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            in_valid,
	input  pcb_pkg::expd_t  in_data,
	output logic            out_valid,
	output logic [31:0]     blended_pixel,
	output logic [15:0]     packed_rgb565
);

	logic [7:0]  sf, df;
	logic [7:0]  src_ch [3];
	logic [7:0]  dst_ch [3];

	logic        valid_s3;
	logic [15:0] sp_s3 [3];
	logic [15:0] dp_s3 [3];

	logic        valid_s4;
	logic [16:0] sum_s4 [3];

	logic [34:0] quo [3];
	logic [7:0]  res [3];

	always_comb begin
		sf = pcb_pkg::factor(in_data.blend.sf_sel, in_data.a, in_data.blend.galpha,
			in_data.ag);
		df = pcb_pkg::factor(in_data.blend.df_sel, in_data.a, in_data.blend.galpha,
			in_data.ag);
		src_ch[0] = in_data.b;
		src_ch[1] = in_data.g;
		src_ch[2] = in_data.r;
		dst_ch[0] = in_data.dest[7:0];
		dst_ch[1] = in_data.dest[15:8];
		dst_ch[2] = in_data.dest[23:16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3  <= 1'b0;
			valid_s4  <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			valid_s3  <= in_valid;
			valid_s4  <= valid_s3;
			out_valid <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				sp_s3[i]  <= 16'(src_ch[i]) * 16'(sf);
				dp_s3[i]  <= 16'(dst_ch[i]) * 16'(df);
				sum_s4[i] <= 17'(sp_s3[i]) + 17'(dp_s3[i]) + pcb_pkg::BLEND_ROUND;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			quo[i] = 35'(sum_s4[i]) * 35'(pcb_pkg::REC255);
			res[i] = (quo[i][pcb_pkg::SH255+8] == 1'b1) ? 8'hff
				: quo[i][pcb_pkg::SH255+7:pcb_pkg::SH255];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			blended_pixel <= {pcb_pkg::OPAQUE, res[2], res[1], res[0]};
			packed_rgb565 <= {res[2][7:3], res[1][7:2], res[0][7:3]};
		end
	end

endmodule

// File: design/pixel_convert_and_blend_core.sv
`timescale 1ns / 1ps
// Top level of the pixel convert and blend core: blend word registers and pipeline.
// Depends on pcb_pkg, pcb_ifs, pcb_expand and pcb_blend.
//
//   Port     Kind        Contents
//   pixel    sink        kind, layer, source_word, dest_pixel
//   result   source      blended_pixel, packed_rgb565
//   cfg_*    write only  cfg_we, cfg_index, cfg_data (blend words a, b, c)
//
// The five register stages all advance together whenever the output register
// is empty or its beat is taken, so throughput is one beat per clock.
// A stall on the result side freezes every stage; nothing is lost or repeated.
// Reset clears the valid bits and the three blend words.
module pixel_convert_and_blend_core (
	input  logic                        clk,
	input  logic                        arst_n,
	pcb_pix_if.sink                     pixel,
	pcb_res_if.source                   result,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [pcb_pkg::WORD_W-1:0]  cfg_data
);

	logic                        adv;
	logic [pcb_pkg::WORD_W-1:0]  blend_q [pcb_pkg::NUM_LAYERS];
	logic                        expd_valid;
	pcb_pkg::expd_t              expd_data;

	assign adv         = !result.valid || result.ready;
	assign pixel.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pcb_pkg::NUM_LAYERS; i++) begin
				blend_q[i] <= '0;
			end
		end else if (cfg_we && (cfg_index < 2'(pcb_pkg::NUM_LAYERS))) begin
			blend_q[cfg_index] <= cfg_data;
		end
	end

	pcb_expand u_expand (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.in_valid    (pixel.valid),
		.kind        (pixel.kind),
		.layer       (pixel.layer),
		.source_word (pixel.source_word),
		.dest_pixel  (pixel.dest_pixel),
		.words       (blend_q),
		.out_valid   (expd_valid),
		.out_data    (expd_data)
	);

	pcb_blend u_blend (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv),
		.in_valid      (expd_valid),
		.in_data       (expd_data),
		.out_valid     (result.valid),
		.blended_pixel (result.blended_pixel),
		.packed_rgb565 (result.packed_rgb565)
	);

endmodule

// File: verif/tb_pixel_convert_and_blend_core.sv
`timescale 1ns / 1ps
// Self-checking testbench of pixel_convert_and_blend_core: directed and random pixels
// under several blend settings and idle patterns, checked against an in-bench predictor.
// Depends on pcb_pkg, pcb_ifs and the design files of the core.
module tb_pixel_convert_and_blend_core;

	localparam logic [1:0] REG_BLEND_A = 2'd0;
	localparam logic [1:0] REG_BLEND_B = 2'd1;
	localparam logic [1:0] REG_BLEND_C = 2'd2;
	localparam int unsigned STALL_LIMIT = 1000;
	localparam int unsigned TAIL_CYCLES = 20;
	localparam int unsigned RANDOM_PHASES = 8;
	localparam int unsigned PIXELS_PER_PHASE = 85;
	localparam pcb_pkg::fsel_t USED_SELECTORS [8] = '{pcb_pkg::FAC_ZERO, pcb_pkg::FAC_ONE,
		pcb_pkg::FAC_INV_A, pcb_pkg::FAC_A, pcb_pkg::FAC_INV_G, pcb_pkg::FAC_G,
		pcb_pkg::FAC_INV_AG, pcb_pkg::FAC_AG};

	typedef struct {
		pcb_pkg::kind_t kind;
		logic [1:0]     layer;
		logic [31:0]    source_word;
		logic [23:0]    dest_pixel;
	} pixel_item_t;

	typedef struct packed {
		logic [31:0] blended_pixel;
		logic [15:0] packed_rgb565;
	} pixel_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [pcb_pkg::WORD_W-1:0] cfg_data;

	pcb_pix_if pixel_ch();
	pcb_res_if result_ch();

	pixel_item_t pending_pixels [$];
	pixel_result_t predicted_pixels [$];
	logic [31:0] blend_words [3];
	pixel_item_t next_pixel;
	pixel_result_t due_pixel;
	int unsigned sender_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned mismatch_count;
	int unsigned quiet_cycles;

	pixel_convert_and_blend_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.pixel(pixel_ch),
		.result(result_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	function automatic logic [7:0] ycc_channel(int v);
		if (v < 0) begin
			return 8'd0;
		end
		if (v / 256 > 255) begin
			return 8'hff;
		end
		return 8'(v / 256);
	endfunction

	function automatic logic [31:0] expand_to_argb(pcb_pkg::kind_t kind, logic [31:0] w);
		int y;
		int cb;
		int cr;
		logic [31:0] argb;
		y = int'(w[23:16]) - 16;
		cb = int'(w[15:8]) - 128;
		cr = int'(w[7:0]) - 128;
		case (kind)
			pcb_pkg::KIND_RGB565: begin
				argb = {pcb_pkg::OPAQUE, 8'(int'(w[15:11]) * 255 / 31),
					8'(int'(w[10:5]) * 255 / 63), 8'(int'(w[4:0]) * 255 / 31)};
			end
			pcb_pkg::KIND_XRGB: begin
				argb = {pcb_pkg::OPAQUE, w[23:0]};
			end
			pcb_pkg::KIND_ARGB: begin
				argb = w;
			end
			default: begin
				argb = {pcb_pkg::OPAQUE, ycc_channel(298 * y + 409 * cr + 128),
					ycc_channel(298 * y - 100 * cb - 208 * cr + 128),
					ycc_channel(298 * y + 516 * cb + 128)};
			end
		endcase
		return argb;
	endfunction

	function automatic int unsigned blend_factor(logic [3:0] sel, int unsigned a,
		int unsigned g);
		case (sel)
			pcb_pkg::FAC_ONE:    return 255;
			pcb_pkg::FAC_INV_A:  return 255 - a;
			pcb_pkg::FAC_A:      return a;
			pcb_pkg::FAC_INV_G:  return 255 - g;
			pcb_pkg::FAC_G:      return g;
			pcb_pkg::FAC_INV_AG: return 255 - a * g / 255;
			pcb_pkg::FAC_AG:     return a * g / 255;
			default:             return 0;
		endcase
	endfunction

	function automatic pixel_result_t blend_pixel(pixel_item_t px);
		logic [31:0] argb;
		logic [31:0] word;
		int unsigned sf;
		int unsigned df;
		int unsigned chan;
		pixel_result_t res;
		argb = expand_to_argb(px.kind, px.source_word);
		word = (px.layer == pcb_pkg::LAYER_CURSOR) ? pcb_pkg::CURSOR_WORD
			: blend_words[px.layer];
		sf = blend_factor(word[31:28], argb[31:24], word[7:0]);
		df = blend_factor(word[15:12], argb[31:24], word[7:0]);
		res.blended_pixel = {pcb_pkg::OPAQUE, 24'h0};
		for (int i = 0; i < 3; i++) begin
			chan = (argb[8 * i +: 8] * sf + px.dest_pixel[8 * i +: 8] * df + 127) / 255;
			res.blended_pixel[8 * i +: 8] = (chan > 255) ? 8'hff : 8'(chan);
		end
		res.packed_rgb565 = {res.blended_pixel[23:19], res.blended_pixel[15:10],
			res.blended_pixel[7:3]};
		return res;
	endfunction

	function automatic logic [31:0] random_blend_word();
		logic [31:0] w;
		w = $urandom;
		if ($urandom_range(4) != 0) begin
			w[31:28] = USED_SELECTORS[$urandom_range(7)];
		end
		if ($urandom_range(4) != 0) begin
			w[15:12] = USED_SELECTORS[$urandom_range(7)];
		end
		if ($urandom_range(3) == 0) begin
			w[7:0] = 8'h00;
		end else if ($urandom_range(2) == 0) begin
			w[7:0] = 8'hff;
		end
		return w;
	endfunction

	task automatic queue_pixel(pcb_pkg::kind_t kind, logic [1:0] layer,
		logic [31:0] source_word, logic [23:0] dest_pixel);
		pixel_item_t px;
		px.kind = kind;
		px.layer = layer;
		px.source_word = source_word;
		px.dest_pixel = dest_pixel;
		pending_pixels.push_back(px);
	endtask

	task automatic queue_random_pixel();
		pixel_item_t px;
		px.kind = pcb_pkg::kind_t'($urandom_range(3));
		px.layer = 2'($urandom_range(3));
		px.source_word = $urandom;
		if (px.kind == pcb_pkg::KIND_ARGB && $urandom_range(2) == 0) begin
			px.source_word[31:24] = ($urandom_range(1) == 0) ? 8'h00 : 8'hff;
		end
		if ($urandom_range(7) == 0) begin
			px.dest_pixel = 24'h000000;
		end else if ($urandom_range(6) == 0) begin
			px.dest_pixel = 24'hffffff;
		end else begin
			px.dest_pixel = 24'($urandom);
		end
		pending_pixels.push_back(px);
	endtask

	task automatic wait_drained();
		do begin
			@(negedge clk);
		end while (pending_pixels.size() != 0 || pixel_ch.valid || predicted_pixels.size() != 0);
	endtask

	task automatic program_blend_words(logic [31:0] word_a, logic [31:0] word_b,
		logic [31:0] word_c);
		logic [31:0] words [3];
		words = '{word_a, word_b, word_c};
		foreach (words[i]) begin
			@(posedge clk);
			cfg_we <= 1'b1;
			cfg_index <= 2'(i);
			cfg_data <= words[i];
			blend_words[i] = words[i];
		end
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_ch.valid <= 1'b0;
			pixel_ch.kind <= pcb_pkg::KIND_RGB565;
			pixel_ch.layer <= 2'd0;
			pixel_ch.source_word <= 32'h0;
			pixel_ch.dest_pixel <= 24'h0;
		end else begin
			if (pixel_ch.valid && pixel_ch.ready) begin
				next_pixel.kind = pcb_pkg::kind_t'(pixel_ch.kind);
				next_pixel.layer = pixel_ch.layer;
				next_pixel.source_word = pixel_ch.source_word;
				next_pixel.dest_pixel = pixel_ch.dest_pixel;
				predicted_pixels.push_back(blend_pixel(next_pixel));
			end
			if (!pixel_ch.valid || pixel_ch.ready) begin
				if (pending_pixels.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					next_pixel = pending_pixels.pop_front();
					pixel_ch.valid <= 1'b1;
					pixel_ch.kind <= next_pixel.kind;
					pixel_ch.layer <= next_pixel.layer;
					pixel_ch.source_word <= next_pixel.source_word;
					pixel_ch.dest_pixel <= next_pixel.dest_pixel;
				end else begin
					pixel_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (predicted_pixels.size() == 0) begin
					$error("result beat with no pixel outstanding: %h", result_ch.blended_pixel);
					mismatch_count++;
				end else begin
					due_pixel = predicted_pixels.pop_front();
					if (result_ch.blended_pixel !== due_pixel.blended_pixel) begin
						$error("blended_pixel: expected %h, got %h", due_pixel.blended_pixel,
							result_ch.blended_pixel);
						mismatch_count++;
					end
					if (result_ch.packed_rgb565 !== due_pixel.packed_rgb565) begin
						$error("packed_rgb565: expected %h, got %h", due_pixel.packed_rgb565,
							result_ch.packed_rgb565);
						mismatch_count++;
					end
				end
			end
			result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (pixel_ch.valid && pixel_ch.ready)
			|| (result_ch.valid && result_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$error("no beat accepted for %0d cycles", STALL_LIMIT);
			$display("tb_pixel_convert_and_blend_core failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_BLEND_A;
		cfg_data = '0;
		blend_words = '{32'h0, 32'h0, 32'h0};
		sender_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Blend words still at their reset value; only the cursor passes anything.
		queue_pixel(pcb_pkg::KIND_ARGB, REG_BLEND_A, 32'hffff_ffff, 24'hffffff);
		queue_pixel(pcb_pkg::KIND_ARGB, REG_BLEND_B, 32'hffff_ffff, 24'hffffff);
		queue_pixel(pcb_pkg::KIND_ARGB, REG_BLEND_C, 32'hffff_ffff, 24'hffffff);
		queue_pixel(pcb_pkg::KIND_XRGB, pcb_pkg::LAYER_CURSOR, 32'h0012_3456, 24'habcdef);
		wait_drained();

		program_blend_words({pcb_pkg::FAC_ONE, 12'h000, pcb_pkg::FAC_ZERO, 4'h0, 8'h00},
			{pcb_pkg::FAC_A, 12'h000, pcb_pkg::FAC_INV_A, 4'h0, 8'h00},
			{pcb_pkg::FAC_ONE, 12'h000, pcb_pkg::FAC_ONE, 4'h0, 8'hff});
		queue_pixel(pcb_pkg::KIND_RGB565, REG_BLEND_A, 32'h0000_0000, 24'h5a5a5a);
		queue_pixel(pcb_pkg::KIND_RGB565, REG_BLEND_A, 32'hffff_0000, 24'hffffff);
		queue_pixel(pcb_pkg::KIND_RGB565, REG_BLEND_A, 32'h0000_ffff, 24'h000000);
		queue_pixel(pcb_pkg::KIND_RGB565, REG_BLEND_A, 32'h0000_f81f, 24'h123456);
		queue_pixel(pcb_pkg::KIND_XRGB, REG_BLEND_B, 32'h00ff_8001, 24'h000000);
		queue_pixel(pcb_pkg::KIND_ARGB, REG_BLEND_B, 32'h00ff_ffff, 24'h123456);
		queue_pixel(pcb_pkg::KIND_ARGB, REG_BLEND_B, 32'h80ff_0000, 24'h0000ff);
		queue_pixel(pcb_pkg::KIND_YCC, REG_BLEND_A, 32'h0000_0000, 24'hffffff);
		queue_pixel(pcb_pkg::KIND_YCC, REG_BLEND_A, 32'h00ff_ffff, 24'h000000);
		queue_pixel(pcb_pkg::KIND_YCC, REG_BLEND_A, 32'h0010_8080, 24'h808080);
		queue_pixel(pcb_pkg::KIND_YCC, REG_BLEND_A, 32'hffeb_8080, 24'h000000);
		queue_pixel(pcb_pkg::KIND_YCC, REG_BLEND_B, 32'h0051_5af0, 24'h00ff00);
		queue_pixel(pcb_pkg::KIND_XRGB, REG_BLEND_C, 32'h00ff_ffff, 24'hffffff);
		queue_pixel(pcb_pkg::KIND_XRGB, REG_BLEND_C, 32'h0080_8080, 24'h808080);
		queue_pixel(pcb_pkg::KIND_ARGB, pcb_pkg::LAYER_CURSOR, 32'h0011_2233, 24'hffffff);
		wait_drained();

		program_blend_words({pcb_pkg::FAC_INV_G, 12'hfff, pcb_pkg::FAC_G, 4'hf, 8'h40},
			{pcb_pkg::FAC_AG, 12'h000, pcb_pkg::FAC_INV_AG, 4'h0, 8'h80},
			{pcb_pkg::FAC_G, 12'h000, pcb_pkg::FAC_INV_G, 4'h0, 8'h00});
		queue_pixel(pcb_pkg::KIND_ARGB, REG_BLEND_A, 32'h80aa_bbcc, 24'h336699);
		queue_pixel(pcb_pkg::KIND_ARGB, REG_BLEND_B, 32'h80aa_bbcc, 24'h336699);
		queue_pixel(pcb_pkg::KIND_ARGB, REG_BLEND_C, 32'h80aa_bbcc, 24'h336699);
		queue_pixel(pcb_pkg::KIND_RGB565, REG_BLEND_B, 32'h1234_a5a5, 24'hfedcba);
		wait_drained();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p == 0) begin
				program_blend_words(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
			end else if (p == 1) begin
				program_blend_words(32'h0000_0000, random_blend_word(), random_blend_word());
			end else begin
				program_blend_words(random_blend_word(), random_blend_word(),
					random_blend_word());
			end
			case (p % 4)
				0: begin
					sender_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					sender_idle_pct = 69;
					recv_stall_pct = 0;
				end
				2: begin
					sender_idle_pct = 0;
					recv_stall_pct = 69;
				end
				default: begin
					sender_idle_pct = 27;
					recv_stall_pct = 27;
				end
			endcase
			repeat (PIXELS_PER_PHASE) queue_random_pixel();
			wait_drained();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("tb_pixel_convert_and_blend_core passed");
		end else begin
			$display("tb_pixel_convert_and_blend_core failed");
		end
		$finish;
	end

endmodule
